### rtl/core/record_sort_unique_defines.svh
// assertion macros used by the record_sort_unique rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef RECORD_SORT_UNIQUE_DEFINES_SVH
`define RECORD_SORT_UNIQUE_DEFINES_SVH

// property checked on every clock edge out of reset
`define RSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition in one cycle implies a property in the same cycle
`define RSU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// condition in one cycle implies a property in the next cycle
`define RSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/rsu_pkg.sv
// shared types, constants and helpers for record_sort_unique
// no dependencies
package rsu_pkg;

    localparam int CAPACITY_DEF         = 256;
    localparam int MAX_RECORD_BYTES_DEF = 20;
    localparam int FULL_RECORD_BYTES    = 20;
    localparam int REC_BITS             = 8 * FULL_RECORD_BYTES;
    localparam int CNT_OUT_W            = 9;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_DUPLICATE = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_DRAINED   = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [63:0] key_high;
        logic [63:0] key_mid;
        logic [31:0] key_low;
    } t_item;

    typedef struct packed {
        logic [2:0]           status;
        logic [63:0]          out_high;
        logic [63:0]          out_mid;
        logic [31:0]          out_low;
        logic                 is_last;
        logic [CNT_OUT_W-1:0] stored_count;
    } t_result;

    // per-cycle commands broadcast to every cell of the chain
    typedef struct packed {
        logic cmp;
        logic ins;
        logic drn;
    } t_cell_ctl;

    // byte j (byte 0 at the top) is kept when j is below the length
    function automatic logic [REC_BITS-1:0] byte_mask(input logic [4:0] len);
        logic [REC_BITS-1:0] mask;
        mask = '0;
        for (int j = 0; j < FULL_RECORD_BYTES; j++) begin
            if (5'(j) < len) begin
                mask[REC_BITS-1-8*j -: 8] = 8'hFF;
            end
        end
        return mask;
    endfunction

endpackage

### rtl/core/record_sort_unique.sv
// Sorted store of distinct byte records built as a chain of CAPACITY cells, one record
// per cell, kept in ascending order with the smallest record in cell 0. A transaction
// is accepted only while the block is idle and passes through the states IDLE, in
// which it is taken (the key is masked to record_length bytes and registered), CMP, in
// which every cell compares the key with its record and registers the result, and
// APPLY, in which the duplicate flags of all cells are combined and the chain shifts to
// insert or drain. APPLY waits while the output register holds a result that is not yet
// taken, and no new transaction is accepted until the last one has left APPLY; the
// result then sits in an output register, and the next transaction is accepted while it
// waits. The store needs no clearing pass after reset: the occupancy count alone says
// which cells hold records. Depends on rsu_pkg, rsu_cell and record_sort_unique_defines.svh
`include "record_sort_unique_defines.svh"

module record_sort_unique
    import rsu_pkg::*;
#(
    parameter int CAPACITY         = CAPACITY_DEF,
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [4:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_item      i_item,
    output logic       o_valid,
    input  logic       i_stall,
    output t_result    o_result
);

    localparam int RW = 8 * MAX_RECORD_BYTES;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [CW-1:0]  CNT_FULL = CW'(CAPACITY);
    localparam logic [CW-1:0]  CNT_ONE  = CW'(1);
    localparam logic [4:0]     LEN_MAX  = 5'(MAX_RECORD_BYTES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMP   = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [4:0]          r_len;
    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic                r_op;
    logic [RW-1:0]       r_key;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    t_result             r_out;
    t_result             n_out;

    logic                w_accept;
    logic                w_out_free;
    logic                w_commit;
    logic                w_dup;
    logic                w_full;
    logic                w_ins_ok;
    logic                w_drn_ok;
    logic [4:0]          w_len_eff;
    logic [REC_BITS-1:0] w_key_full;
    logic [REC_BITS-1:0] w_head_full;
    t_cell_ctl           w_ctl;

    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_eq;
    logic [RW-1:0]       w_rec [CAPACITY];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 5'(FULL_RECORD_BYTES);
        end else if (i_cfg_wr_en) begin
            r_len <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_len_eff = r_len;
        if (w_len_eff == 5'd0) begin
            w_len_eff = 5'd1;
        end
        if (w_len_eff > LEN_MAX) begin
            w_len_eff = LEN_MAX;
        end
    end

    assign w_key_full = {i_item.key_high, i_item.key_mid, i_item.key_low}
                        & byte_mask(w_len_eff);

    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_dup      = |w_eq;
    assign w_full     = (r_count == CNT_FULL);
    assign w_commit   = (r_state == ST_APPLY) && w_out_free;
    assign w_ins_ok   = (r_op == OP_INSERT) && !w_dup && !w_full;
    assign w_drn_ok   = (r_op == OP_DRAIN) && (r_count != '0);

    assign w_ctl.cmp = (r_state == ST_CMP);
    assign w_ctl.ins = w_commit && w_ins_ok;
    assign w_ctl.drn = w_commit && w_drn_ok;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_item.operation;
            r_key <= w_key_full[REC_BITS-1 -: RW];
        end
    end

    // the cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [RW-1:0] w_left_rec;
        logic [RW-1:0] w_right_rec;
        logic          w_left_gt;

        if (g == 0) begin : g_first
            assign w_left_rec = r_key;
            assign w_left_gt  = 1'b1;
        end else begin : g_inner
            assign w_left_rec = w_rec[g-1];
            assign w_left_gt  = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_rec = '0;
        end else begin : g_body
            assign w_right_rec = w_rec[g+1];
        end

        rsu_cell #(
            .INDEX (g),
            .RW    (RW),
            .CW    (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_key       (r_key),
            .i_left_rec  (w_left_rec),
            .i_right_rec (w_right_rec),
            .i_left_gt   (w_left_gt),
            .o_rec       (w_rec[g]),
            .o_gt        (w_gt[g]),
            .o_eq        (w_eq[g])
        );
    end

    always_comb begin
        w_head_full = '0;
        w_head_full[REC_BITS-1 -: RW] = w_rec[0];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (w_commit) begin
                    n_state  = ST_IDLE;
                    n_out    = '0;
                    if (r_op == OP_INSERT) begin
                        if (w_dup) begin
                            n_out.status = STAT_DUPLICATE;
                        end else if (w_full) begin
                            n_out.status = STAT_FULL;
                        end else begin
                            n_out.status = STAT_INSERTED;
                            n_count      = r_count + CNT_ONE;
                        end
                    end else if (r_count == '0) begin
                        n_out.status = STAT_EMPTY;
                    end else begin
                        n_out.status   = STAT_DRAINED;
                        n_out.out_high = w_head_full[REC_BITS-1 -: 64];
                        n_out.out_mid  = w_head_full[REC_BITS-65 -: 64];
                        n_out.out_low  = w_head_full[31:0];
                        n_out.is_last  = (r_count == CNT_ONE);
                        n_count        = r_count - CNT_ONE;
                    end
                    n_out.stored_count = CNT_OUT_W'(n_count);
                    n_out_valid        = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // stored records are distinct, so at most one cell can match a key
    `RSU_ASSERT_ALWAYS(a_eq_onehot, $onehot0(w_eq), "several cells match the key")
    `RSU_ASSERT_ALWAYS(a_count_range, r_count <= CNT_FULL, "occupancy above capacity")
    `RSU_ASSERT_NEXT(a_ins_count, w_ctl.ins, r_count == $past(r_count) + CNT_ONE, "insert miscounted")
    `RSU_ASSERT_SAME(a_last_flag, o_valid && (o_result.status == STAT_DRAINED), o_result.is_last == (o_result.stored_count == '0), "is_last does not match count")

endmodule

### rtl/core/rsu_cell.sv
// one cell of the sorted record chain: holds one record and its compare flags
// depends on rsu_pkg
module rsu_cell
    import rsu_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int RW    = REC_BITS,
    parameter int CW    = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    input  logic [RW-1:0] i_key,
    input  logic [RW-1:0] i_left_rec,
    input  logic [RW-1:0] i_right_rec,
    input  logic          i_left_gt,
    output logic [RW-1:0] o_rec,
    output logic          o_gt,
    output logic          o_eq
);

    localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

    logic [RW-1:0] r_rec;
    logic [RW-1:0] n_rec;
    logic          r_gt;
    logic          n_gt;
    logic          r_eq;
    logic          n_eq;
    logic          w_occ;

    assign w_occ = (MY_IDX < i_count);

    always_comb begin
        n_gt = r_gt;
        n_eq = r_eq;
        if (i_ctl.cmp) begin
            n_gt = w_occ && (i_key > r_rec);
            n_eq = w_occ && (i_key == r_rec);
        end
    end

    // insert: cells below the key keep, the first other cell takes the key,
    // the rest move one place up; drain: everything moves one place down
    always_comb begin
        n_rec = r_rec;
        if (i_ctl.ins) begin
            if (r_gt) begin
                n_rec = r_rec;
            end else if (i_left_gt) begin
                n_rec = i_key;
            end else begin
                n_rec = i_left_rec;
            end
        end else if (i_ctl.drn) begin
            n_rec = i_right_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
        if (!i_rst_n) begin
            r_gt <= 1'b0;
            r_eq <= 1'b0;
        end else begin
            r_gt <= n_gt;
            r_eq <= n_eq;
        end
    end

    assign o_rec = r_rec;
    assign o_gt  = r_gt;
    assign o_eq  = r_eq;

endmodule
